FILE: design/allm_pkg.sv
// Shared types, codes and widths of the array linked list manager.
package allm_pkg;

  // Fixed field widths of the request and result ports
  localparam int unsigned ACTION_W   = 3;
  localparam int unsigned DATA_W     = 64;
  localparam int unsigned POS_W      = 16;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned SLOT_OUT_W = 8;

  // Request action codes
  localparam logic [ACTION_W-1:0] ACT_HEAD   = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_TAIL   = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_AFTER  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_BEFORE = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_DELETE = 3'd4;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd3;

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_WRITE1,
    ST_WRITE2,
    ST_FINISH
  } ctrl_state_e;

  // Decoded kind of the request in flight
  typedef enum logic [3:0] {
    K_NOP,
    K_FULL,
    K_RANGE,
    K_EMPTY,
    K_HEAD,
    K_TAIL,
    K_AFTER,
    K_BEFORE,
    K_DEL
  } kind_e;

  // Controller to datapath commands
  typedef struct packed {
    logic clear_wr;
    logic latch_req;
    logic rd_en;
    logic resolve;
    logic write1;
    logic write2;
    logic load_out;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic  clear_last;
    kind_e kind;
  } stat_t;

endpackage

FILE: design/array_linked_list_manager.sv
// Top level of the array linked list manager.
// Keeps a doubly linked list in slot memories with slot 0 as sentinel and a free
// list of unused slots; each request inserts at head, tail, after or before a slot,
// or deletes a slot, and returns one result with status, slot, removed value,
// head, tail, count and order flag. Requests are handled one at a time. After
// reset the block runs a clearing pass over all slots that initializes the
// slot links, with in_ready_o low. A request that changes the list steps through
// accept, memory read, two link write steps and result; an insert before a slot
// that is not the head first adds a predecessor read and decode, and goes from
// there to the result if its reference slot turns out to be free. Requests that
// end in an error status or change nothing go from the read to the result.
// The two write steps follow from the single write port of each slot memory and
// the registered read that must precede the writes. The result sits in an output
// register, so it can wait for out_ready_i while the next request is accepted.
module array_linked_list_manager #(
  parameter int unsigned SLOT_COUNT = 256,
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [allm_pkg::ACTION_W-1:0]    action_i,
  input  logic [allm_pkg::DATA_W-1:0]      data_word_i,
  input  logic [allm_pkg::POS_W-1:0]       slot_position_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [allm_pkg::STATUS_W-1:0]    status_o,
  output logic [allm_pkg::SLOT_OUT_W-1:0]  slot_used_o,
  output logic [allm_pkg::DATA_W-1:0]      removed_value_o,
  output logic [allm_pkg::SLOT_OUT_W-1:0]  head_slot_o,
  output logic [allm_pkg::SLOT_OUT_W-1:0]  tail_slot_o,
  output logic [allm_pkg::SLOT_OUT_W-1:0]  entry_count_o,
  output logic                             in_order_o
);

  allm_pkg::cmd_t  cmd;
  allm_pkg::stat_t stat;

  // Sequencer
  allm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Slot memories and list state
  allm_dpath #(
    .SLOT_COUNT (SLOT_COUNT),
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .action_i        (action_i),
    .data_word_i     (data_word_i),
    .slot_position_i (slot_position_i),
    .status_o        (status_o),
    .slot_used_o     (slot_used_o),
    .removed_value_o (removed_value_o),
    .head_slot_o     (head_slot_o),
    .tail_slot_o     (tail_slot_o),
    .entry_count_o   (entry_count_o),
    .in_order_o      (in_order_o)
  );

endmodule

FILE: design/allm_ctrl.sv
// Sequencing state machine of the array linked list manager.
module allm_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  allm_pkg::stat_t  stat_i,
  output allm_pkg::cmd_t   cmd_o
);

  allm_pkg::ctrl_state_e state_q, state_d;
  logic                  out_valid_q, out_valid_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      allm_pkg::ST_CLEAR: begin
        if (stat_i.clear_last) state_d = allm_pkg::ST_IDLE;
      end
      allm_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = allm_pkg::ST_READ;
      end
      allm_pkg::ST_READ: begin
        if (stat_i.kind inside {allm_pkg::K_NOP, allm_pkg::K_FULL,
                                allm_pkg::K_RANGE, allm_pkg::K_EMPTY}) begin
          state_d = allm_pkg::ST_FINISH;
        end else if (stat_i.kind == allm_pkg::K_BEFORE) begin
          state_d = allm_pkg::ST_CHECK;
        end else begin
          state_d = allm_pkg::ST_WRITE1;
        end
      end
      allm_pkg::ST_CHECK:  state_d = allm_pkg::ST_READ;
      allm_pkg::ST_WRITE1: state_d = allm_pkg::ST_WRITE2;
      allm_pkg::ST_WRITE2: state_d = allm_pkg::ST_FINISH;
      allm_pkg::ST_FINISH: begin
        if (!out_valid_q || out_ready_i) state_d = allm_pkg::ST_IDLE;
      end
      default: state_d = allm_pkg::ST_CLEAR;
    endcase
  end

  // Commands per state
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      allm_pkg::ST_CLEAR:  cmd_o.clear_wr = 1'b1;
      allm_pkg::ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.latch_req = in_valid_i;
      end
      allm_pkg::ST_READ:   cmd_o.rd_en   = 1'b1;
      allm_pkg::ST_CHECK:  cmd_o.resolve = 1'b1;
      allm_pkg::ST_WRITE1: cmd_o.write1  = 1'b1;
      allm_pkg::ST_WRITE2: cmd_o.write2  = 1'b1;
      allm_pkg::ST_FINISH: cmd_o.load_out = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  // Hold the result valid until it is taken; a new load keeps it high
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= allm_pkg::ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  // An accepted request always starts with a read of the slot memories
  a_accept_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == allm_pkg::ST_IDLE && in_valid_i) |=> state_q == allm_pkg::ST_READ)
    else $error("accepted request did not move to the read step");

  // A finished result waits while the output register is still occupied
  a_finish_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == allm_pkg::ST_FINISH && out_valid_q && !out_ready_i)
      |=> (state_q == allm_pkg::ST_FINISH && out_valid_q))
    else $error("result overwrote an untaken output");
`endif

endmodule

FILE: design/allm_dpath.sv
// Slot memories, list pointers and result register of the linked list manager.
module allm_dpath #(
  parameter int unsigned SLOT_COUNT = 256,
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  allm_pkg::cmd_t                      cmd_i,
  output allm_pkg::stat_t                     stat_o,
  input  logic [allm_pkg::ACTION_W-1:0]       action_i,
  input  logic [allm_pkg::DATA_W-1:0]         data_word_i,
  input  logic [allm_pkg::POS_W-1:0]          slot_position_i,
  output logic [allm_pkg::STATUS_W-1:0]       status_o,
  output logic [allm_pkg::SLOT_OUT_W-1:0]     slot_used_o,
  output logic [allm_pkg::DATA_W-1:0]         removed_value_o,
  output logic [allm_pkg::SLOT_OUT_W-1:0]     head_slot_o,
  output logic [allm_pkg::SLOT_OUT_W-1:0]     tail_slot_o,
  output logic [allm_pkg::SLOT_OUT_W-1:0]     entry_count_o,
  output logic                                in_order_o
);

  localparam int unsigned SW = $clog2(SLOT_COUNT);
  localparam int unsigned PW = SW + 1;
  localparam logic [SW-1:0] LAST_SLOT = SW'(SLOT_COUNT - 1);
  localparam logic [PW-1:0] FREE_MARK = PW'(SLOT_COUNT);
  localparam logic [allm_pkg::POS_W:0] POS_LIMIT = (allm_pkg::POS_W + 1)'(SLOT_COUNT);

  // Slot memories
  logic [SW-1:0]         next_mem  [SLOT_COUNT];
  logic [PW-1:0]         prev_mem  [SLOT_COUNT];
  logic [VALUE_BITS-1:0] value_mem [SLOT_COUNT];

  // List state
  logic [SW-1:0] head_q, tail_q, free_q, count_q, clr_q;
  logic          linear_q;
  allm_pkg::kind_e kind_q, kind_d, kind_res;

  // Request and read data
  logic [SW-1:0]         ref_q, slot_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [SW-1:0]         nxa_rd, nxb_rd;
  logic [PW-1:0]         pv_rd;
  logic [VALUE_BITS-1:0] sv_rd;

  // Write ports
  logic                  nx_we, pv_we, sv_we;
  logic [SW-1:0]         nx_wa, pv_wa, sv_wa, nx_wd;
  logic [PW-1:0]         pv_wd;
  logic [VALUE_BITS-1:0] sv_wd;

  // Result register
  logic [allm_pkg::STATUS_W-1:0]   status_q;
  logic [allm_pkg::SLOT_OUT_W-1:0] slot_out_q, head_out_q, tail_out_q, count_out_q;
  logic [allm_pkg::DATA_W-1:0]     removed_q;
  logic                            linear_out_q;

  logic [allm_pkg::POS_W:0] pos_ext;
  logic [SW-1:0]            count_inc, count_dec, tail_new;
  logic                     ref_is_head, ref_is_tail, head_is_tail, pv_live;

  assign pos_ext      = {1'b0, slot_position_i};
  assign count_inc    = (count_q < LAST_SLOT) ? count_q + 1'b1 : count_q;
  assign count_dec    = (count_q != '0) ? count_q - 1'b1 : count_q;
  assign pv_live      = pv_rd < FREE_MARK;
  assign tail_new     = pv_live ? pv_rd[SW-1:0] : '0;
  assign ref_is_head  = ref_q == head_q;
  assign ref_is_tail  = ref_q == tail_q;
  assign head_is_tail = head_q == tail_q;

  assign stat_o.clear_last = clr_q == LAST_SLOT;
  assign stat_o.kind       = kind_q;

  // Decode the incoming request against the current list state
  always_comb begin
    kind_d = allm_pkg::K_NOP;
    if (action_i <= allm_pkg::ACT_BEFORE && free_q == '0) begin
      kind_d = allm_pkg::K_FULL;
    end else begin
      case (action_i)
        allm_pkg::ACT_HEAD: kind_d = allm_pkg::K_HEAD;
        allm_pkg::ACT_TAIL: kind_d = allm_pkg::K_TAIL;
        allm_pkg::ACT_AFTER: begin
          if (pos_ext == (allm_pkg::POS_W + 1)'(tail_q)) kind_d = allm_pkg::K_TAIL;
          else if (pos_ext >= POS_LIMIT)                 kind_d = allm_pkg::K_RANGE;
          else                                           kind_d = allm_pkg::K_AFTER;
        end
        allm_pkg::ACT_BEFORE: begin
          if (pos_ext == (allm_pkg::POS_W + 1)'(head_q)) kind_d = allm_pkg::K_HEAD;
          else if (pos_ext >= POS_LIMIT)                 kind_d = allm_pkg::K_RANGE;
          else                                           kind_d = allm_pkg::K_BEFORE;
        end
        allm_pkg::ACT_DELETE: begin
          if (pos_ext >= POS_LIMIT)  kind_d = allm_pkg::K_RANGE;
          else if (count_q == '0)    kind_d = allm_pkg::K_EMPTY;
          else                       kind_d = allm_pkg::K_DEL;
        end
        default: kind_d = allm_pkg::K_NOP;
      endcase
    end
  end

  // Turn insert-before into insert-after its predecessor (tail path at the tail, range error if free)
  always_comb begin
    if (pv_rd == PW'(tail_q)) kind_res = allm_pkg::K_TAIL;
    else if (!pv_live)        kind_res = allm_pkg::K_RANGE;
    else                      kind_res = allm_pkg::K_AFTER;
  end

  // Select memory writes: clearing pass, early link fixups, final slot writes
  always_comb begin
    nx_we = 1'b0;  nx_wa = ref_q;  nx_wd = '0;
    pv_we = 1'b0;  pv_wa = ref_q;  pv_wd = '0;
    sv_we = 1'b0;  sv_wa = ref_q;  sv_wd = '0;
    if (cmd_i.clear_wr) begin
      nx_we = 1'b1;  nx_wa = clr_q;
      nx_wd = (clr_q == '0 || clr_q == LAST_SLOT) ? '0 : clr_q + 1'b1;
      pv_we = 1'b1;  pv_wa = clr_q;
      pv_wd = (clr_q == '0) ? '0 : FREE_MARK;
      sv_we = 1'b1;  sv_wa = clr_q;
    end else if (cmd_i.write1) begin
      case (kind_q)
        allm_pkg::K_HEAD: begin
          pv_we = 1'b1;  pv_wa = head_q;  pv_wd = PW'(free_q);
        end
        allm_pkg::K_TAIL: begin
          nx_we = 1'b1;  nx_wa = tail_q;  nx_wd = free_q;
        end
        allm_pkg::K_AFTER: begin
          nx_we = 1'b1;  nx_wa = ref_q;   nx_wd = free_q;
          pv_we = 1'b1;  pv_wa = nxb_rd;  pv_wd = PW'(free_q);
        end
        allm_pkg::K_DEL: begin
          if (ref_is_head) begin
            pv_we = !head_is_tail;  pv_wa = nxb_rd;  pv_wd = '0;
          end else if (ref_is_tail) begin
            nx_we = 1'b1;  nx_wa = tail_new;  nx_wd = '0;
          end else begin
            // drop the forward write when the predecessor is the free marker
            nx_we = pv_live;  nx_wa = pv_rd[SW-1:0];  nx_wd = nxb_rd;
            pv_we = 1'b1;     pv_wa = nxb_rd;         pv_wd = pv_rd;
          end
        end
        default: ;
      endcase
    end else if (cmd_i.write2) begin
      case (kind_q)
        allm_pkg::K_HEAD: begin
          nx_we = 1'b1;  nx_wa = free_q;  nx_wd = head_q;
          pv_we = 1'b1;  pv_wa = free_q;  pv_wd = '0;
          sv_we = 1'b1;  sv_wa = free_q;  sv_wd = val_q;
        end
        allm_pkg::K_TAIL: begin
          nx_we = 1'b1;  nx_wa = free_q;  nx_wd = '0;
          pv_we = 1'b1;  pv_wa = free_q;  pv_wd = PW'(tail_q);
          sv_we = 1'b1;  sv_wa = free_q;  sv_wd = val_q;
        end
        allm_pkg::K_AFTER: begin
          nx_we = 1'b1;  nx_wa = free_q;  nx_wd = nxb_rd;
          pv_we = 1'b1;  pv_wa = free_q;  pv_wd = PW'(ref_q);
          sv_we = 1'b1;  sv_wa = free_q;  sv_wd = val_q;
        end
        allm_pkg::K_DEL: begin
          nx_we = 1'b1;  nx_wa = ref_q;  nx_wd = free_q;
          pv_we = 1'b1;  pv_wa = ref_q;  pv_wd = FREE_MARK;
          sv_we = 1'b1;  sv_wa = ref_q;  sv_wd = '0;
        end
        default: ;
      endcase
    end
  end

  // Next-link memory: one write, two registered reads
  always_ff @(posedge clk_i) begin
    if (nx_we) next_mem[nx_wa] <= nx_wd;
    if (cmd_i.rd_en) begin
      nxa_rd <= next_mem[free_q];
      nxb_rd <= next_mem[ref_q];
    end
  end

  // Prev-link memory
  always_ff @(posedge clk_i) begin
    if (pv_we) prev_mem[pv_wa] <= pv_wd;
    if (cmd_i.rd_en) pv_rd <= prev_mem[ref_q];
  end

  // Value memory
  always_ff @(posedge clk_i) begin
    if (sv_we) value_mem[sv_wa] <= sv_wd;
    if (cmd_i.rd_en) sv_rd <= value_mem[ref_q];
  end

  // Latch request payload, the predecessor on resolve, and the slot reported with the result
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_req) begin
      ref_q <= slot_position_i[SW-1:0];
      val_q <= VALUE_BITS'(data_word_i);
    end else if (cmd_i.resolve) begin
      ref_q <= pv_rd[SW-1:0];
    end
    if (cmd_i.write2) slot_q <= (kind_q == allm_pkg::K_DEL) ? ref_q : free_q;
  end

  // Update list pointers, count and order flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      tail_q   <= '0;
      free_q   <= SW'(1);
      count_q  <= '0;
      linear_q <= 1'b1;
      clr_q    <= '0;
      kind_q   <= allm_pkg::K_NOP;
    end else begin
      if (cmd_i.clear_wr) clr_q <= clr_q + 1'b1;
      if (cmd_i.latch_req) begin
        kind_q <= kind_d;
      end else if (cmd_i.resolve) begin
        kind_q <= kind_res;
      end
      if (cmd_i.write2) begin
        case (kind_q)
          allm_pkg::K_HEAD: begin
            free_q  <= nxa_rd;
            head_q  <= free_q;
            count_q <= count_inc;
            if (count_q == '0) tail_q <= free_q;
            else               linear_q <= 1'b0;
          end
          allm_pkg::K_TAIL: begin
            free_q  <= nxa_rd;
            tail_q  <= free_q;
            count_q <= count_inc;
            if (count_q == '0) head_q <= free_q;
          end
          allm_pkg::K_AFTER: begin
            free_q   <= nxa_rd;
            count_q  <= count_inc;
            linear_q <= 1'b0;
          end
          allm_pkg::K_DEL: begin
            free_q  <= ref_q;
            count_q <= count_dec;
            if (ref_is_head) begin
              if (head_is_tail) begin
                head_q <= '0;
                tail_q <= '0;
              end else begin
                head_q   <= nxb_rd;
                linear_q <= 1'b0;
              end
            end else if (ref_is_tail) begin
              tail_q <= tail_new;
            end else begin
              linear_q <= 1'b0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      case (kind_q)
        allm_pkg::K_RANGE: status_q <= allm_pkg::STATUS_RANGE;
        allm_pkg::K_EMPTY: status_q <= allm_pkg::STATUS_EMPTY;
        allm_pkg::K_FULL:  status_q <= allm_pkg::STATUS_FULL;
        default:           status_q <= allm_pkg::STATUS_OK;
      endcase
      slot_out_q   <= (kind_q inside {allm_pkg::K_HEAD, allm_pkg::K_TAIL,
                                      allm_pkg::K_AFTER, allm_pkg::K_DEL})
                      ? allm_pkg::SLOT_OUT_W'(slot_q) : '0;
      removed_q    <= (kind_q == allm_pkg::K_DEL) ? allm_pkg::DATA_W'(sv_rd) : '0;
      head_out_q   <= allm_pkg::SLOT_OUT_W'(head_q);
      tail_out_q   <= allm_pkg::SLOT_OUT_W'(tail_q);
      count_out_q  <= allm_pkg::SLOT_OUT_W'(count_q);
      linear_out_q <= linear_q;
    end
  end

  assign status_o        = status_q;
  assign slot_used_o     = slot_out_q;
  assign removed_value_o = removed_q;
  assign head_slot_o     = head_out_q;
  assign tail_slot_o     = tail_out_q;
  assign entry_count_o   = count_out_q;
  assign in_order_o      = linear_out_q;

`ifndef SYNTH
  // Link fixups only run for requests that change the list
  a_write_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.write1 |-> (kind_q == allm_pkg::K_HEAD || kind_q == allm_pkg::K_TAIL ||
                      kind_q == allm_pkg::K_AFTER || kind_q == allm_pkg::K_DEL))
    else $error("link write issued for a request that changes nothing");

  // Resolving insert-before never leaves it unresolved
  a_resolved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cmd_i.resolve) |-> kind_q != allm_pkg::K_BEFORE)
    else $error("insert-before still pending after resolve");

  // The entry count moves only on the final write step
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> $past(cmd_i.write2))
    else $error("entry count changed outside the final write step");
`endif

endmodule

FILE: tb/tb_array_linked_list_manager.sv
// Self-checking testbench for the array linked list manager.
`timescale 1ns / 100ps

module tb_array_linked_list_manager;

  localparam int unsigned SLOTS = 256;
  localparam logic [8:0] FREE_MARKER = 9'd256;
  localparam logic [allm_pkg::ACTION_W-1:0] ACT_UNUSED_MAX = '1;
  localparam int unsigned RANDOM_REQUESTS = 1500;
  localparam int unsigned IDLE_PCT = 27;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES = 20;

  typedef logic [allm_pkg::ACTION_W-1:0] action_t;

  // One result as the block reports it
  typedef struct packed {
    logic [allm_pkg::STATUS_W-1:0]   status;
    logic [allm_pkg::SLOT_OUT_W-1:0] slot;
    logic [allm_pkg::DATA_W-1:0]     removed;
    logic [allm_pkg::SLOT_OUT_W-1:0] head;
    logic [allm_pkg::SLOT_OUT_W-1:0] tail;
    logic [allm_pkg::SLOT_OUT_W-1:0] count;
    logic                            in_order;
  } list_result_t;

  // One directed request, with a hand-typed result where it is obvious
  typedef struct {
    logic [allm_pkg::ACTION_W-1:0] act;
    logic [allm_pkg::DATA_W-1:0]   value;
    logic [allm_pkg::POS_W-1:0]    pos;
    bit                            typed;
    list_result_t                  want;
  } request_row_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            in_valid_i = 1'b0;
  logic                            in_ready_o;
  logic [allm_pkg::ACTION_W-1:0]   action_i = allm_pkg::ACT_HEAD;
  logic [allm_pkg::DATA_W-1:0]     data_word_i = '0;
  logic [allm_pkg::POS_W-1:0]      slot_position_i = '0;
  logic                            out_valid_o;
  logic                            out_ready_i = 1'b0;
  logic [allm_pkg::STATUS_W-1:0]   status_o;
  logic [allm_pkg::SLOT_OUT_W-1:0] slot_used_o;
  logic [allm_pkg::DATA_W-1:0]     removed_value_o;
  logic [allm_pkg::SLOT_OUT_W-1:0] head_slot_o;
  logic [allm_pkg::SLOT_OUT_W-1:0] tail_slot_o;
  logic [allm_pkg::SLOT_OUT_W-1:0] entry_count_o;
  logic                            in_order_o;

  // Shadow copy of the slot memories and list pointers
  logic [7:0]  lnk_next [SLOTS];
  logic [8:0]  lnk_prev [SLOTS];
  logic [63:0] slot_val [SLOTS];
  logic [7:0]  list_head;
  logic [7:0]  list_tail;
  logic [7:0]  free_head;
  logic [7:0]  live_total;
  logic        still_linear;

  list_result_t pending_results [$];
  logic [7:0]   chain_slots [$];
  int unsigned  errors = 0;
  int unsigned  results_seen = 0;
  int unsigned  stall_cycles = 0;
  bit           calm = 1'b0;

  array_linked_list_manager dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .action_i        (action_i),
    .data_word_i     (data_word_i),
    .slot_position_i (slot_position_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .slot_used_o     (slot_used_o),
    .removed_value_o (removed_value_o),
    .head_slot_o     (head_slot_o),
    .tail_slot_o     (tail_slot_o),
    .entry_count_o   (entry_count_o),
    .in_order_o      (in_order_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Report one failure and count it
  task automatic flag_error(string msg);
    errors++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) begin
      flag_error($sformatf("result %0d %s: got %0h, expected %0h",
                           results_seen, name, got, want));
    end
  endtask

  function automatic void bump_count();
    if (live_total != 8'd255) live_total += 8'd1;
  endfunction

  // Pop the first slot off the free chain
  function automatic logic [7:0] grab_free_slot();
    logic [7:0] s;
    s = free_head;
    free_head = lnk_next[s];
    return s;
  endfunction

  function automatic logic [7:0] link_at_head(logic [63:0] v);
    logic [7:0] s;
    s = grab_free_slot();
    lnk_prev[list_head] = {1'b0, s};
    slot_val[s] = v;
    lnk_next[s] = list_head;
    lnk_prev[s] = '0;
    list_head = s;
    if (live_total == 0) list_tail = s;
    else still_linear = 1'b0;
    bump_count();
    return s;
  endfunction

  function automatic logic [7:0] link_at_tail(logic [63:0] v);
    logic [7:0] s;
    s = grab_free_slot();
    lnk_next[list_tail] = s;
    slot_val[s] = v;
    lnk_prev[s] = {1'b0, list_tail};
    lnk_next[s] = '0;
    list_tail = s;
    if (live_total == 0) list_head = s;
    bump_count();
    return s;
  endfunction

  // Insert after a reference slot; the tail case goes through the tail path
  function automatic logic [allm_pkg::STATUS_W-1:0] link_after(input logic [63:0] v,
                                                               input logic [15:0] pos,
                                                               output logic [7:0] slot);
    logic [7:0] s;
    logic [7:0] nxt;
    slot = '0;
    if (pos == {8'd0, list_tail}) begin
      slot = link_at_tail(v);
      return allm_pkg::STATUS_OK;
    end
    if (pos >= SLOTS) return allm_pkg::STATUS_RANGE;
    s = grab_free_slot();
    nxt = lnk_next[pos[7:0]];
    lnk_next[pos[7:0]] = s;
    lnk_prev[nxt] = {1'b0, s};
    lnk_prev[s] = {1'b0, pos[7:0]};
    lnk_next[s] = nxt;
    slot_val[s] = v;
    bump_count();
    still_linear = 1'b0;
    slot = s;
    return allm_pkg::STATUS_OK;
  endfunction

  // Unlink a slot and push it on the free chain
  function automatic logic [allm_pkg::STATUS_W-1:0] unlink(input logic [15:0] pos,
                                                           output logic [63:0] removed);
    logic [7:0] p8;
    logic [8:0] back;
    logic [7:0] fwd;
    logic [7:0] old_free;
    removed = '0;
    if (pos >= SLOTS) return allm_pkg::STATUS_RANGE;
    if (live_total == 0) return allm_pkg::STATUS_EMPTY;
    p8 = pos[7:0];
    removed = slot_val[p8];
    slot_val[p8] = '0;
    if (p8 == list_head) begin
      if (list_head == list_tail) begin
        list_head = '0;
        list_tail = '0;
      end else begin
        list_head = lnk_next[list_head];
        lnk_prev[list_head] = '0;
        still_linear = 1'b0;
      end
    end else if (p8 == list_tail) begin
      back = lnk_prev[list_tail];
      list_tail = (back >= FREE_MARKER) ? 8'd0 : back[7:0];
      lnk_next[list_tail] = '0;
    end else begin
      back = lnk_prev[p8];
      fwd = lnk_next[p8];
      // a link holding the free marker points nowhere
      if (back < FREE_MARKER) lnk_next[back[7:0]] = fwd;
      lnk_prev[fwd] = back;
      still_linear = 1'b0;
    end
    old_free = free_head;
    free_head = p8;
    lnk_prev[p8] = FREE_MARKER;
    lnk_next[p8] = old_free;
    if (live_total != 0) live_total -= 8'd1;
    return allm_pkg::STATUS_OK;
  endfunction

  // Advance the shadow list by one request and return its result
  function automatic list_result_t apply_request(logic [allm_pkg::ACTION_W-1:0] act,
                                                 logic [63:0] v, logic [15:0] pos);
    list_result_t r;
    logic [allm_pkg::STATUS_W-1:0] st;
    logic [7:0] slot;
    logic [63:0] gone;
    st = allm_pkg::STATUS_OK;
    slot = '0;
    gone = '0;
    if (act <= allm_pkg::ACT_BEFORE && free_head == 8'd0) begin
      st = allm_pkg::STATUS_FULL;
    end else begin
      case (act)
        allm_pkg::ACT_HEAD: slot = link_at_head(v);
        allm_pkg::ACT_TAIL: slot = link_at_tail(v);
        allm_pkg::ACT_AFTER: st = link_after(v, pos, slot);
        allm_pkg::ACT_BEFORE: begin
          if (pos == {8'd0, list_head}) slot = link_at_head(v);
          else if (pos >= SLOTS) st = allm_pkg::STATUS_RANGE;
          else st = link_after(v, {7'd0, lnk_prev[pos[7:0]]}, slot);
        end
        allm_pkg::ACT_DELETE: begin
          st = unlink(pos, gone);
          if (st == allm_pkg::STATUS_OK) slot = pos[7:0];
        end
        default: ;
      endcase
    end
    if (st != allm_pkg::STATUS_OK) slot = '0;
    r = '{st, slot, gone, list_head, list_tail, live_total, still_linear};
    return r;
  endfunction

  // Collect the live slots by walking from the head
  function automatic void gather_chain();
    logic [7:0] s;
    chain_slots.delete();
    s = list_head;
    while (s != 8'd0 && chain_slots.size() < live_total) begin
      chain_slots.push_back(s);
      s = lnk_next[s];
    end
  endfunction

  function automatic request_row_t plain_row(logic [allm_pkg::ACTION_W-1:0] act,
                                             logic [63:0] value, logic [15:0] pos);
    request_row_t r;
    r.act = act;
    r.value = value;
    r.pos = pos;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic request_row_t known_row(logic [allm_pkg::ACTION_W-1:0] act,
                                             logic [63:0] value, logic [15:0] pos,
                                             logic [allm_pkg::STATUS_W-1:0] st,
                                             logic [7:0] slot,
                                             logic [7:0] head, logic [7:0] tail,
                                             logic [7:0] count, logic in_order);
    request_row_t r;
    r = plain_row(act, value, pos);
    r.typed = 1'b1;
    r.want = '{st, slot, 64'd0, head, tail, count, in_order};
    return r;
  endfunction

  // Offer one request, hold it until accepted, then queue its result
  task automatic send_request(logic [allm_pkg::ACTION_W-1:0] act, logic [63:0] value,
                              logic [15:0] pos, bit typed, list_result_t want);
    list_result_t predicted;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    data_word_i <= value;
    slot_position_i <= pos;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = apply_request(act, value, pos);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // Accept results with random stalls and compare against the oldest request
  always @(posedge clk_i) begin
    list_result_t got;
    list_result_t want;
    if (out_valid_o && out_ready_i) begin
      got = {status_o, slot_used_o, removed_value_o, head_slot_o, tail_slot_o,
             entry_count_o, in_order_o};
      if (pending_results.size() == 0) begin
        flag_error("result with no request outstanding");
      end else begin
        want = pending_results.pop_front();
        check_field("status", 64'(got.status), 64'(want.status));
        check_field("slot_used", 64'(got.slot), 64'(want.slot));
        check_field("removed_value", got.removed, want.removed);
        check_field("head_slot", 64'(got.head), 64'(want.head));
        check_field("tail_slot", 64'(got.tail), 64'(want.tail));
        check_field("entry_count", 64'(got.count), 64'(want.count));
        check_field("in_order", 64'(got.in_order), 64'(want.in_order));
      end
      results_seen++;
    end
    out_ready_i <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == STALL_LIMIT) begin
      $display("TIMEOUT at %0t", $time);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    request_row_t directed_plan [$];
    logic [allm_pkg::ACTION_W-1:0] act;
    logic [63:0] value;
    logic [15:0] pos;
    int unsigned roll;
    int unsigned insert_pct;

    // Shadow state as it stands after the clearing pass
    for (int i = 0; i < SLOTS; i++) begin
      lnk_next[i] = 8'(i + 1);
      lnk_prev[i] = FREE_MARKER;
      slot_val[i] = '0;
    end
    lnk_next[SLOTS-1] = '0;
    lnk_next[0] = '0;
    lnk_prev[0] = '0;
    list_head = '0;
    list_tail = '0;
    free_head = 8'd1;
    live_total = '0;
    still_linear = 1'b1;

    // Errors and no-ops on the fresh list, then one insert of each kind
    directed_plan.push_back(known_row(allm_pkg::ACT_DELETE, '0, 16'd5,
                                      allm_pkg::STATUS_EMPTY, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1));
    directed_plan.push_back(known_row(allm_pkg::ACT_DELETE, '0, 16'hFFFF,
                                      allm_pkg::STATUS_RANGE, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1));
    directed_plan.push_back(known_row(allm_pkg::ACT_AFTER, '1, 16'h8000,
                                      allm_pkg::STATUS_RANGE, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1));
    directed_plan.push_back(known_row(allm_pkg::ACT_BEFORE, '1, 16'd300,
                                      allm_pkg::STATUS_RANGE, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1));
    // free slot as reference: its back link is the free marker
    directed_plan.push_back(known_row(allm_pkg::ACT_BEFORE, '1, 16'd7,
                                      allm_pkg::STATUS_RANGE, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1));
    directed_plan.push_back(known_row(allm_pkg::ACT_DELETE + 3'd1, '1, 16'd1,
                                      allm_pkg::STATUS_OK, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1));
    directed_plan.push_back(known_row(allm_pkg::ACT_DELETE + 3'd2, '0, 16'd0,
                                      allm_pkg::STATUS_OK, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1));
    directed_plan.push_back(known_row(ACT_UNUSED_MAX, '1, 16'hFFFF,
                                      allm_pkg::STATUS_OK, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1));
    directed_plan.push_back(known_row(allm_pkg::ACT_HEAD, '0, 16'd0,
                                      allm_pkg::STATUS_OK, 8'd1, 8'd1, 8'd1, 8'd1, 1'b1));
    directed_plan.push_back(plain_row(allm_pkg::ACT_TAIL, '1, 16'd0));
    // after the tail, before the head, then both in the middle
    directed_plan.push_back(plain_row(allm_pkg::ACT_AFTER, 64'h8000_0000_0000_0000, 16'd2));
    directed_plan.push_back(plain_row(allm_pkg::ACT_BEFORE, 64'h0000_0000_0000_0001, 16'd1));
    directed_plan.push_back(plain_row(allm_pkg::ACT_AFTER, 64'h0123_4567_89AB_CDEF, 16'd1));
    directed_plan.push_back(plain_row(allm_pkg::ACT_BEFORE, 64'hFEDC_BA98_7654_3210, 16'd3));
    // delete head, tail and a middle slot
    directed_plan.push_back(plain_row(allm_pkg::ACT_DELETE, '0, 16'd4));
    directed_plan.push_back(plain_row(allm_pkg::ACT_DELETE, '1, 16'd3));
    directed_plan.push_back(plain_row(allm_pkg::ACT_DELETE, '0, 16'd5));
    directed_plan.push_back(plain_row(allm_pkg::ACT_DELETE, '0, 16'd256));
    directed_plan.push_back(plain_row(allm_pkg::ACT_AFTER, '1, 16'hFFFF));
    directed_plan.push_back(plain_row(allm_pkg::ACT_BEFORE, '1, 16'hFFFF));
    directed_plan.push_back(plain_row(ACT_UNUSED_MAX, '1, 16'hFFFF));
    directed_plan.push_back(plain_row(allm_pkg::ACT_HEAD, 64'hA5A5_A5A5_A5A5_A5A5, 16'd0));
    directed_plan.push_back(plain_row(allm_pkg::ACT_TAIL, 64'h5A5A_5A5A_5A5A_5A5A, 16'd0));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_plan[i]) begin
      send_request(directed_plan[i].act, directed_plan[i].value, directed_plan[i].pos,
                   directed_plan[i].typed, directed_plan[i].want);
    end

    // Random part: fill to full, churn, drain to empty, churn, then abuse links
    for (int k = 0; k < RANDOM_REQUESTS; k++) begin
      calm = (k >= 500 && k < 700);
      if (k == 0 || k == 750) begin
        // hold off until every outstanding result is back
        in_valid_i <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk_i);
      end
      gather_chain();
      insert_pct = (k < 450) ? 85 : (k < 700) ? 50 : (k < 1100) ? 10 : 55;
      value = {$urandom, $urandom};
      case ($urandom_range(15))
        0: value = '0;
        1: value = '1;
        default: ;
      endcase
      pos = (chain_slots.size() != 0) ?
            16'(chain_slots[$urandom_range(chain_slots.size() - 1)]) : 16'd0;
      roll = $urandom_range(99);
      if (roll < 3) begin
        act = action_t'($urandom_range(ACT_UNUSED_MAX, allm_pkg::ACT_DELETE + 3'd1));
        pos = 16'($urandom_range(16'hFFFF));
      end else if (roll < 6) begin
        act = action_t'($urandom_range(allm_pkg::ACT_DELETE, allm_pkg::ACT_AFTER));
        pos = 16'($urandom_range(16'hFFFF, SLOTS));
      end else if (k >= 1350 && roll < 11) begin
        // reference or delete a slot that may not be live
        act = action_t'($urandom_range(allm_pkg::ACT_DELETE, allm_pkg::ACT_AFTER));
        pos = 16'($urandom_range(SLOTS - 1));
      end else if ($urandom_range(99) < insert_pct) begin
        act = action_t'($urandom_range(allm_pkg::ACT_BEFORE, allm_pkg::ACT_HEAD));
      end else begin
        act = allm_pkg::ACT_DELETE;
        if (chain_slots.size() == 0) pos = 16'($urandom_range(SLOTS - 1, 1));
      end
      send_request(act, value, pos, 1'b0, '0);
    end
    calm = 1'b0;

    // Drain, then keep watching the outputs for anything stray
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/allm_pkg.sv
design/allm_ctrl.sv
design/allm_dpath.sv
design/array_linked_list_manager.sv
tb/tb_array_linked_list_manager.sv
